// ----- src/tsrrs_pkg.sv -----
// thread slot scheduler package: slot count, derived widths, slot states and codes
// no dependencies

package tsrrs_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int WAIT_W = $clog2(SLOTS + 1);

    localparam logic [WAIT_W-1:0] WAIT_NONE = WAIT_W'(SLOTS);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_DEAD     = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_BLOCKED  = 2'd3
    } t_slot_st;

    typedef enum logic [1:0] {
        ACT_CREATE = 2'd0,
        ACT_EXIT   = 2'd1,
        ACT_JOIN   = 2'd2,
        ACT_YIELD  = 2'd3
    } t_action;

    localparam logic [1:0] RES_OK    = 2'd0;
    localparam logic [1:0] RES_FULL  = 2'd1;
    localparam logic [1:0] RES_NORUN = 2'd2;

endpackage

// ----- src/thread_state_round_robin_scheduler.sv -----
// thread slot scheduler top level: slot table, current slot and scan sequencer
// depends on tsrrs_pkg
//
// usage: pulse start with i_action and i_target while busy is low; that cycle
// accepts the transaction; busy rises until the result is out, save for an out-of-range join.
// o_valid is high for exactly one cycle with o_active, o_new_id and o_status;
// the receiver cannot stall, so the result must be taken in that cycle.
// busy is already low in the o_valid cycle, so the next start may coincide.
// sequence after acceptance, scanning one slot per cycle:
//   create: scan upward for the lowest dead slot
//   exit:   wake-up sweep over all slots, then round-robin search
//   yield:  round-robin search
//   join:   the accepting edge gives the result if the target is out of range,
//           the check state if it is dead or the current slot, else the switch
// one transaction at a time: a new start is taken only while busy is low.
// reset (synchronous, active low) makes slot 0 running and current, all
// other slots dead, and every wait entry none; no clearing pass is needed.

module thread_state_round_robin_scheduler
    import tsrrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_action,
    input  logic [3:0] i_target,
    output logic       busy,
    output logic       o_valid,
    output logic [3:0] o_active,
    output logic [3:0] o_new_id,
    output logic [1:0] o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE,
        S_WAKE,
        S_SEARCH,
        S_JCHK,
        S_JRUN
    } t_state;

    t_state              r_state;
    t_action             r_action;
    t_slot_st            r_slot_st [SLOTS];
    logic [WAIT_W-1:0]   r_wait [SLOTS];
    logic [IDX_W-1:0]    r_cur;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_cnt;
    logic                r_valid;
    logic [3:0]          r_active;
    logic [3:0]          r_new_id;
    logic [1:0]          r_status;

    logic                t_in_range;
    t_slot_st            rd_st;
    logic [WAIT_W-1:0]   rd_wait;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == IDX_LAST) begin
            r = '0;
        end else begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    assign t_in_range = (32'(i_target) < SLOTS);
    assign rd_st      = r_slot_st[r_idx];
    assign rd_wait    = r_wait[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_valid <= 1'b0;
            for (int j = 0; j < SLOTS; j++) begin
                r_slot_st[j] <= (j == 0) ? ST_RUNNING : ST_DEAD;
                r_wait[j]    <= WAIT_NONE;
            end
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_action <= t_action'(i_action);
                        r_cnt    <= '0;
                        unique case (t_action'(i_action))
                            ACT_CREATE: begin
                                r_idx   <= '0;
                                r_state <= S_CREATE;
                            end
                            ACT_EXIT: begin
                                r_idx   <= '0;
                                r_state <= S_WAKE;
                            end
                            ACT_JOIN: begin
                                if (t_in_range) begin
                                    r_idx   <= IDX_W'(i_target);
                                    r_state <= S_JCHK;
                                end else begin
                                    r_valid  <= 1'b1;
                                    r_active <= 4'(r_cur);
                                    r_new_id <= '0;
                                    r_status <= RES_OK;
                                end
                            end
                            ACT_YIELD: begin
                                r_slot_st[r_cur] <= ST_RUNNABLE;
                                r_idx            <= f_next(r_cur);
                                r_state          <= S_SEARCH;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CREATE: begin
                    if (rd_st == ST_DEAD) begin
                        r_slot_st[r_idx] <= ST_RUNNABLE;
                        r_wait[r_idx]    <= WAIT_NONE;
                        r_valid          <= 1'b1;
                        r_active         <= 4'(r_cur);
                        r_new_id         <= 4'(r_idx);
                        r_status         <= RES_OK;
                        r_state          <= S_IDLE;
                    end else if (r_idx == IDX_LAST) begin
                        r_valid  <= 1'b1;
                        r_active <= 4'(r_cur);
                        r_new_id <= '0;
                        r_status <= RES_FULL;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_WAKE: begin
                    // current slot dies, its joiners wake
                    if (rd_wait == WAIT_W'(r_cur)) begin
                        r_wait[r_idx]    <= WAIT_NONE;
                        r_slot_st[r_idx] <= ST_RUNNABLE;
                    end else if (r_idx == r_cur) begin
                        r_slot_st[r_idx] <= ST_DEAD;
                    end
                    if (r_idx == IDX_LAST) begin
                        r_idx   <= f_next(r_cur);
                        r_cnt   <= '0;
                        r_state <= S_SEARCH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SEARCH: begin
                    if (rd_st == ST_RUNNABLE) begin
                        r_slot_st[r_idx] <= ST_RUNNING;
                        r_cur            <= r_idx;
                        r_valid          <= 1'b1;
                        r_active         <= 4'(r_idx);
                        r_new_id         <= '0;
                        r_status         <= RES_OK;
                        r_state          <= S_IDLE;
                    end else if (r_cnt == IDX_LAST) begin
                        r_valid  <= 1'b1;
                        r_active <= 4'(r_cur);
                        r_new_id <= '0;
                        r_status <= (r_action == ACT_EXIT) ? RES_NORUN : RES_OK;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx <= f_next(r_idx);
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_JCHK: begin
                    if (r_idx != r_cur && rd_st != ST_DEAD) begin
                        r_slot_st[r_cur] <= ST_BLOCKED;
                        r_wait[r_cur]    <= WAIT_W'(r_idx);
                        r_state          <= S_JRUN;
                    end else begin
                        r_valid  <= 1'b1;
                        r_active <= 4'(r_cur);
                        r_new_id <= '0;
                        r_status <= RES_OK;
                        r_state  <= S_IDLE;
                    end
                end
                S_JRUN: begin
                    r_slot_st[r_idx] <= ST_RUNNING;
                    r_cur            <= r_idx;
                    r_valid          <= 1'b1;
                    r_active         <= 4'(r_idx);
                    r_new_id         <= '0;
                    r_status         <= RES_OK;
                    r_state          <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_active = r_active;
    assign o_new_id = r_new_id;
    assign o_status = r_status;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !(t_action'(i_action) == ACT_JOIN && !t_in_range)) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while sequencer busy");

    a_full_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != RES_OK) |-> (o_new_id == 4'd0))
        else $error("nonzero new id on failed transaction");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == RES_OK || o_status == RES_FULL || o_status == RES_NORUN))
        else $error("undefined status code");
`endif

endmodule

// ----- sim/tsrrs_checker.sv -----
`timescale 1ns / 1ps
// scoreboard for the thread slot scheduler: keeps its own slot table, predicts each result
// depends on tsrrs_pkg; watches the command and result ports of the block

module tsrrs_checker
    import tsrrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] i_action,
    input  logic [3:0] i_target,
    input  logic       o_valid,
    input  logic [3:0] o_active,
    input  logic [3:0] o_new_id,
    input  logic [1:0] o_status,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [3:0] active;
        logic [3:0] new_id;
        logic [1:0] status;
    } t_outcome;

    t_slot_st          slot_st  [SLOTS];
    logic [WAIT_W-1:0] waits_for[SLOTS];
    logic [IDX_W-1:0]  cur_slot;
    t_outcome          outcome_q[$];
    int                mismatches = 0;
    int                in_flight  = 0;

    assign fail_count = mismatches;
    assign pending    = in_flight;

    // round-robin search from the slot after the current one
    function automatic logic hand_off();
        int idx;
        idx = (int'(cur_slot) + 1) % SLOTS;
        for (int k = 0; k < SLOTS; k++) begin
            if (slot_st[idx] == ST_RUNNABLE) begin
                slot_st[idx] = ST_RUNNING;
                cur_slot     = IDX_W'(idx);
                return 1'b1;
            end
            idx = (idx + 1) % SLOTS;
        end
        return 1'b0;
    endfunction

    function automatic t_outcome schedule_step(t_action act, logic [3:0] tgt);
        t_outcome r;
        int       free;
        r.new_id = '0;
        r.status = RES_OK;
        case (act)
            ACT_CREATE: begin
                free = -1;
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (slot_st[i] == ST_DEAD) free = i;
                end
                if (free < 0) begin
                    r.status = RES_FULL;
                end else begin
                    slot_st[free]   = ST_RUNNABLE;
                    waits_for[free] = WAIT_NONE;
                    r.new_id        = 4'(free);
                end
            end
            ACT_EXIT: begin
                slot_st[cur_slot] = ST_DEAD;
                // joiners wake up, dead or not
                for (int i = 0; i < SLOTS; i++) begin
                    if (waits_for[i] == WAIT_W'(cur_slot)) begin
                        waits_for[i] = WAIT_NONE;
                        slot_st[i]   = ST_RUNNABLE;
                    end
                end
                if (!hand_off()) r.status = RES_NORUN;
            end
            ACT_JOIN: begin
                if (int'(tgt) < SLOTS && int'(tgt) != int'(cur_slot)
                        && slot_st[tgt] != ST_DEAD) begin
                    slot_st[cur_slot]   = ST_BLOCKED;
                    waits_for[cur_slot] = WAIT_W'(tgt);
                    slot_st[tgt]        = ST_RUNNING;
                    cur_slot            = IDX_W'(tgt);
                end
            end
            default: begin
                slot_st[cur_slot] = ST_RUNNABLE;
                void'(hand_off());
            end
        endcase
        r.active = 4'(cur_slot);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_st[i]   = ST_DEAD;
                waits_for[i] = WAIT_NONE;
            end
            slot_st[0] = ST_RUNNING;
            cur_slot   = '0;
            outcome_q.delete();
        end else begin
            if (o_valid) begin
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result: active %0d new_id %0d status %0d",
                                 $realtime, o_active, o_new_id, o_status);
                end else begin
                    want = outcome_q.pop_front();
                    if (o_active !== want.active || o_new_id !== want.new_id
                            || o_status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: exp/got active %0d/%0d new_id %0d/%0d status %0d/%0d",
                                     $realtime, want.active, o_active, want.new_id, o_new_id,
                                     want.status, o_status);
                    end
                end
            end
            if (start && !busy)
                outcome_q.push_back(schedule_step(t_action'(i_action), i_target));
        end
        in_flight = outcome_q.size();
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// top of the thread slot scheduler regression: clock, reset, directed and random commands
// depends on tsrrs_pkg, thread_state_round_robin_scheduler and tsrrs_checker

module testbench;
    import tsrrs_pkg::*;

    localparam int LIMIT = 300000;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       start    = 1'b0;
    logic [1:0] i_action = ACT_CREATE;
    logic [3:0] i_target = 4'd0;
    logic       busy;
    logic       o_valid;
    logic [3:0] o_active;
    logic [3:0] o_new_id;
    logic [1:0] o_status;
    int         fail_count;
    int         pending;
    int         cycles = 0;

    thread_state_round_robin_scheduler dut (.*);

    tsrrs_checker u_checker (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic issue(input t_action act, input logic [3:0] tgt);
        logic taken;
        start    <= 1'b1;
        i_action <= act;
        i_target <= tgt;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic t_action pick_action(int w_create, int w_exit, int w_join);
        int roll;
        roll = $urandom_range(99);
        if (roll < w_create) return ACT_CREATE;
        if (roll < w_create + w_exit) return ACT_EXIT;
        if (roll < w_create + w_exit + w_join) return ACT_JOIN;
        return ACT_YIELD;
    endfunction

    task automatic run_phase(int count, int w_create, int w_exit, int w_join, bit quiet);
        for (int n = 0; n < count; n++) begin
            if (!quiet && $urandom_range(99) < 18) begin
                start    <= 1'b0;
                i_action <= 2'($urandom);
                i_target <= 4'($urandom);
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            issue(pick_action(w_create, w_exit, w_join), 4'($urandom_range(15)));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // exit with nothing else alive, then yield back into the dead slot
        issue(ACT_EXIT, 4'd0);
        issue(ACT_YIELD, 4'd15);
        // fill the table, the last create finds it full
        repeat (16) issue(ACT_CREATE, 4'd15);
        issue(ACT_JOIN, 4'd0);
        issue(ACT_JOIN, 4'd15);
        issue(ACT_JOIN, 4'd0);
        // exit wakes the joiner
        issue(ACT_EXIT, 4'd0);
        issue(ACT_YIELD, 4'd0);
        issue(ACT_EXIT, 4'd0);
        issue(ACT_JOIN, 4'd2);

        run_phase(300, 40, 20, 20, 1'b0);
        drain();
        run_phase(300, 25, 25, 25, 1'b1);
        run_phase(300, 25, 35, 20, 1'b0);
        run_phase(200, 30, 15, 40, 1'b0);

        drain();
        repeat (2 * SLOTS + 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
